// ===== rtl/core/edq_pkg.sv =====
// ----------------------------------------------------------------------------
// edq_pkg: shared types and constants of the event deque
// sizes, operation and status codes, and the structs passed along the cell row
// ----------------------------------------------------------------------------
package edq_pkg;

  localparam int DEPTH    = 16;
  localparam int ID_WIDTH = 16;
  localparam int HANDLE_W = 16;
  localparam int KEY_W    = 16;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_FIND       = 3'd5
  } edq_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } edq_status_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ID_WIDTH-1:0] ident;
  } edq_entry_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic                load_prev;      // push front accepted
    logic                load_in_slot;   // push back accepted
    logic                load_next_all;  // pop front accepted
    logic                load_next_hit;  // remove: shift at and behind the hit
    logic [HANDLE_W-1:0] key_handle;
    logic [ID_WIDTH-1:0] key_ident;
    edq_entry_t          item;
  } edq_cmd_t;

  // per-cell position flags
  typedef struct packed {
    logic occupied;
    logic tail;
    logic push_slot;
  } edq_slot_t;

  // values rippling from the front cell to the back
  typedef struct packed {
    logic                hit_handle;
    logic                hit_ident;
    logic [HANDLE_W-1:0] find_handle;
    logic [HANDLE_W-1:0] tail_handle;
  } edq_chain_t;

endpackage

// ===== rtl/core/edq_cell.sv =====
// ----------------------------------------------------------------------------
// edq_cell: one slot of the deque
// holds an entry, compares it against the keys and shifts toward either side
// ----------------------------------------------------------------------------
module edq_cell (
  input  logic                clk,
  input  edq_pkg::edq_cmd_t   cmd,
  input  edq_pkg::edq_slot_t  slot,
  input  edq_pkg::edq_entry_t prev_entry,
  input  edq_pkg::edq_entry_t next_entry,
  input  edq_pkg::edq_chain_t chain_in,
  output edq_pkg::edq_entry_t entry,
  output edq_pkg::edq_chain_t chain_out
);
  import edq_pkg::*;

  edq_entry_t entry_r;
  edq_entry_t entry_nxt;
  logic       match_handle;
  logic       match_ident;

  assign match_handle = slot.occupied && (entry_r.handle == cmd.key_handle);
  assign match_ident  = slot.occupied && (entry_r.ident == cmd.key_ident);

  always_comb begin
    chain_out.hit_handle  = chain_in.hit_handle | match_handle;
    chain_out.hit_ident   = chain_in.hit_ident | match_ident;
    chain_out.find_handle = chain_in.hit_ident ? chain_in.find_handle :
                            (match_ident ? entry_r.handle : '0);
    chain_out.tail_handle = slot.tail ? entry_r.handle : chain_in.tail_handle;
  end

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.load_prev) begin
      entry_nxt = prev_entry;
    end else if (cmd.load_in_slot && slot.push_slot) begin
      entry_nxt = cmd.item;
    end else if (cmd.load_next_all || (cmd.load_next_hit && chain_out.hit_handle)) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== rtl/core/event_deque_with_key_ops.sv =====
// ----------------------------------------------------------------------------
// event_deque_with_key_ops: ordered list of event entries with key operations
// double-ended queue of handle/identifier pairs built as a row of cells
// ----------------------------------------------------------------------------
// The list sits in a row of DEPTH cells with the front entry in cell 0. Every
// operation (push front, push back, pop front, pop back, remove by handle,
// find by identifier) goes through the row at once: each cell compares its own entry to
// the keys in parallel, first-match flags ripple down the row, and the cells
// shift one place toward either end in the same edge. One transaction is
// worked on at a time; its result lands in an output register, and a new
// transaction is taken in the cycle that result is taken (or whenever the
// register is empty): one transaction per cycle while results are taken.
// Every transaction gives exactly one result with the handle popped or found,
// a status code and the entry count after the operation. Cell contents are
// not reset; only the count and output valid are, so there is no clearing pass.
// ----------------------------------------------------------------------------
module event_deque_with_key_ops (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [edq_pkg::OP_W-1:0]      in_operation,
  input  logic [edq_pkg::HANDLE_W-1:0]  in_handle,
  input  logic [edq_pkg::KEY_W-1:0]     in_event_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [edq_pkg::HANDLE_W-1:0]  out_result_handle,
  output logic [edq_pkg::STATUS_W-1:0]  out_status,
  output logic [edq_pkg::CNT_W-1:0]     out_entry_count
);
  import edq_pkg::*;

  // occupancy and output register
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  edq_status_t         status_r, status_nxt;

  logic                accept;
  edq_op_t             op;
  logic                is_empty;
  logic                is_full;
  logic                push_ok;
  edq_cmd_t            cmd;
  logic [ID_WIDTH-1:0] in_ident;

  edq_entry_t cell_entry [DEPTH];
  edq_chain_t chain [DEPTH+1];

  // a new transaction enters once the previous result is gone or leaving
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = edq_op_t'(in_operation);
  assign in_ident = ID_WIDTH'(in_event_id);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(DEPTH));
  // a null handle is refused before fullness is checked
  assign push_ok  = (in_handle != '0) && !is_full;

  // commands broadcast to the row
  always_comb begin
    cmd               = '0;
    cmd.key_handle    = in_handle;
    cmd.key_ident     = in_ident;
    cmd.item.handle   = in_handle;
    cmd.item.ident    = in_ident;
    if (accept) begin
      cmd.load_prev     = (op == OP_PUSH_FRONT) && push_ok;
      cmd.load_in_slot  = (op == OP_PUSH_BACK) && push_ok;
      cmd.load_next_all = (op == OP_POP_FRONT) && !is_empty;
      cmd.load_next_hit = (op == OP_REMOVE);
    end
  end

  // head of the first-match chain
  assign chain[0] = '0;

  // row of cells; cell 0 takes the new item on push front, the last cell
  // keeps its own entry when the row shifts toward the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    edq_slot_t  slot;
    edq_entry_t prev_e;
    edq_entry_t next_e;

    assign slot.occupied  = (CNT_W'(i) < count_r);
    assign slot.tail      = (CNT_W'(i + 1) == count_r);
    assign slot.push_slot = (CNT_W'(i) == count_r);

    if (i == 0) begin : g_first
      assign prev_e = cmd.item;
    end else begin : g_prev
      assign prev_e = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_e = cell_entry[i];
    end else begin : g_next
      assign next_e = cell_entry[i+1];
    end

    edq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .slot       (slot),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .chain_in   (chain[i]),
      .entry      (cell_entry[i]),
      .chain_out  (chain[i+1])
    );
  end

  // result and count for the transaction on the input side
  always_comb begin
    res_handle_nxt = '0;
    status_nxt     = ST_NONE;
    count_nxt      = count_r;
    unique case (op) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (in_handle == '0) begin
          status_nxt = ST_NONE;
        end else if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_DONE;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (!is_empty) begin
          res_handle_nxt = cell_entry[0].handle;
          status_nxt     = ST_DONE;
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (!is_empty) begin
          res_handle_nxt = chain[DEPTH].tail_handle;
          status_nxt     = ST_DONE;
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        // remove also brings the count down
        if (chain[DEPTH].hit_handle) begin
          status_nxt = ST_DONE;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      OP_FIND: begin
        if (chain[DEPTH].hit_ident) begin
          res_handle_nxt = chain[DEPTH].find_handle;
          status_nxt     = ST_DONE;
        end
      end
      default: begin
        // unused operation codes leave the list alone
        status_nxt = ST_NONE;
      end
    endcase
  end

  // output valid follows accepts and takes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res_handle_r <= res_handle_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_handle = res_handle_r;
  assign out_status        = status_r;
  assign out_entry_count   = count_r;

  // count never runs past the row length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // a held result freezes the list
  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(count_r))
    else $error("count moved while result stalled");

  // a push of a real handle into a full list is reported as full
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && in_handle != '0
     && is_full) |=> (status_r == ST_FULL && count_r == CNT_W'(DEPTH)))
    else $error("full push not rejected");

  // pushes and removes never return a handle
  a_push_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK || op == OP_REMOVE))
    |=> (res_handle_r == '0))
    else $error("handle returned by push or remove");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the event deque
// drives random and directed deque transactions through the input channel,
// keeps a shadow list of the entries, and checks every result in order
// ----------------------------------------------------------------------------
module testbench;
  import edq_pkg::*;

  // run shape
  localparam int RANDOM_ITEMS = 1600;  // counted items, ignored ones excluded
  localparam int QUIET_TAIL   = 200;   // last items go through with no idling
  localparam int LONG_HOLD    = 80;    // receiver hold-off, in cycles
  localparam int HOLD_AFTER   = 500;   // transactions taken before the hold-off
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int POOL_HANDLES = 20;    // small handle pool so removes hit
  localparam int POOL_IDS     = 16;

  // operation codes the block has no meaning for
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    ev_id;
  } deque_cmd_t;

  typedef struct {
    logic [HANDLE_W-1:0] handle;
    edq_status_t         status;
    logic [CNT_W-1:0]    count;
  } deque_outcome_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation = '0;
  logic [HANDLE_W-1:0] in_handle    = '0;
  logic [KEY_W-1:0]    in_event_id  = '0;

  // result channel
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [HANDLE_W-1:0] out_result_handle;
  logic [STATUS_W-1:0] out_status;
  logic [CNT_W-1:0]    out_entry_count;

  // shadow copy of the list, front entry at index 0
  logic [HANDLE_W-1:0] shadow_handle [DEPTH];
  logic [ID_WIDTH-1:0] shadow_ident  [DEPTH];
  int                  shadow_count = 0;

  deque_cmd_t     cmd_backlog[$];        // transactions not yet offered
  deque_outcome_t expected_results[$];   // results owed by the block
  deque_cmd_t     cur_cmd;
  int             items_taken = 0;
  int             mismatches  = 0;
  int             cycle_count = 0;
  logic           timed_out   = 1'b0;

  event_deque_with_key_ops dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_handle         (in_handle),
    .in_event_id       (in_event_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_handle (out_result_handle),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle counter and watchdog flag
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      timed_out <= 1'b1;
    end
  end

  // apply one transaction to the shadow list and return what the block owes
  function automatic deque_outcome_t deque_apply(input deque_cmd_t c);
    deque_outcome_t      o;
    logic [ID_WIDTH-1:0] key;
    int                  hit;
    o.handle = '0;
    o.status = ST_NONE;
    key      = c.ev_id[ID_WIDTH-1:0];
    hit      = -1;
    case (c.op)
      OP_PUSH_FRONT: begin
        // null handle wins over a full list
        if (c.handle != '0) begin
          if (shadow_count >= DEPTH) begin
            o.status = ST_FULL;
          end else begin
            for (int i = shadow_count; i > 0; i--) begin
              shadow_handle[i] = shadow_handle[i-1];
              shadow_ident[i]  = shadow_ident[i-1];
            end
            shadow_handle[0] = c.handle;
            shadow_ident[0]  = key;
            shadow_count++;
            o.status = ST_DONE;
          end
        end
      end
      OP_PUSH_BACK: begin
        if (c.handle != '0) begin
          if (shadow_count >= DEPTH) begin
            o.status = ST_FULL;
          end else begin
            shadow_handle[shadow_count] = c.handle;
            shadow_ident[shadow_count]  = key;
            shadow_count++;
            o.status = ST_DONE;
          end
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count > 0) begin
          o.handle = shadow_handle[0];
          for (int i = 0; i < shadow_count - 1; i++) begin
            shadow_handle[i] = shadow_handle[i+1];
            shadow_ident[i]  = shadow_ident[i+1];
          end
          shadow_count--;
          o.status = ST_DONE;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count > 0) begin
          o.handle = shadow_handle[shadow_count-1];
          shadow_count--;
          o.status = ST_DONE;
        end
      end
      OP_REMOVE: begin
        // first matching handle only, entries behind it close the gap
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_handle[i] == c.handle) hit = i;
        end
        if (hit >= 0) begin
          for (int i = hit; i < shadow_count - 1; i++) begin
            shadow_handle[i] = shadow_handle[i+1];
            shadow_ident[i]  = shadow_ident[i+1];
          end
          shadow_count--;
          o.status = ST_DONE;
        end
      end
      OP_FIND: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_ident[i] == key) hit = i;
        end
        if (hit >= 0) begin
          o.handle = shadow_handle[hit];
          o.status = ST_DONE;
        end
      end
      default: begin
        // spare codes change nothing
      end
    endcase
    o.count = CNT_W'(shadow_count);
    return o;
  endfunction

  task automatic flag_mismatch(input string field, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, field, got, want);
    mismatches++;
  endtask

  task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] hnd,
                           input logic [KEY_W-1:0] id);
    deque_cmd_t c;
    c.op     = op;
    c.handle = hnd;
    c.ev_id  = id;
    cmd_backlog.push_back(c);
  endtask

  // driver: offers backlog transactions, with random gaps away from the tail
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // transaction taken at this edge, work out its result now
      if (in_valid && in_ready) begin
        expected_results.push_back(deque_apply(cur_cmd));
        items_taken++;
      end
      if (in_valid && !in_ready) begin
        // hold the offered transaction until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        cur_cmd = cmd_backlog.pop_front();
        in_valid     <= 1'b1;
        in_operation <= cur_cmd.op;
        in_handle    <= cur_cmd.handle;
        in_event_id  <= cur_cmd.ev_id;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off that backs the block up
  int stall_left = 0;
  int hold_left  = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && items_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (cmd_backlog.size() > QUIET_TAIL && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: every taken result against the oldest expectation
  always @(posedge clk) begin
    deque_outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result, count", out_entry_count, -1);
      end else begin
        want = expected_results.pop_front();
        if (out_result_handle !== want.handle)
          flag_mismatch("result_handle", out_result_handle, want.handle);
        if (out_status !== want.status)
          flag_mismatch("status", out_status, want.status);
        if (out_entry_count !== want.count)
          flag_mismatch("entry_count", out_entry_count, want.count);
      end
    end
  end

  // handle: mostly from a small pool so removes and duplicates happen
  function automatic logic [HANDLE_W-1:0] pick_handle();
    if ($urandom_range(0, 99) < 80) return HANDLE_W'($urandom_range(1, POOL_HANDLES));
    return HANDLE_W'($urandom_range(1, 65535));
  endfunction

  function automatic logic [KEY_W-1:0] pick_ident();
    if ($urandom_range(0, 99) < 70) return KEY_W'($urandom_range(0, POOL_IDS - 1));
    return KEY_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    int   counted;
    int   episode_left;
    logic filling;
    int   roll;

    // directed: empty-list cases, spare codes, null pushes
    queue_cmd(OP_POP_FRONT,  16'h0000, 16'h0000);
    queue_cmd(OP_POP_BACK,   16'h0000, 16'hffff);
    queue_cmd(OP_REMOVE,     16'h0000, 16'h0000);
    queue_cmd(OP_FIND,       16'h0000, 16'h0000);
    queue_cmd(OP_SPARE_6,    16'hffff, 16'hffff);
    queue_cmd(OP_SPARE_7,    16'h1234, 16'h5678);
    queue_cmd(OP_PUSH_FRONT, 16'h0000, 16'h0001);
    queue_cmd(OP_PUSH_BACK,  16'h0000, 16'hffff);
    // directed: build a short list with extreme handles and ids
    queue_cmd(OP_PUSH_BACK,  16'hffff, 16'hffff);
    queue_cmd(OP_PUSH_FRONT, 16'h0001, 16'h0000);
    queue_cmd(OP_PUSH_BACK,  16'h8000, 16'h1234);
    queue_cmd(OP_PUSH_FRONT, 16'h5555, 16'haaaa);
    // directed: find hits and a miss
    queue_cmd(OP_FIND,       16'h0000, 16'hffff);
    queue_cmd(OP_FIND,       16'h0000, 16'h1234);
    queue_cmd(OP_FIND,       16'h0000, 16'h7777);
    // directed: remove of null, of a handle not held, then from middle and front
    queue_cmd(OP_REMOVE,     16'h0000, 16'h0000);
    queue_cmd(OP_REMOVE,     16'h4242, 16'h0000);
    queue_cmd(OP_REMOVE,     16'h0001, 16'h0000);
    queue_cmd(OP_REMOVE,     16'h5555, 16'h0000);
    // directed: drain from both ends, then pop the empty list again
    queue_cmd(OP_POP_BACK,   16'h0000, 16'h0000);
    queue_cmd(OP_POP_FRONT,  16'h0000, 16'h0000);
    queue_cmd(OP_POP_FRONT,  16'h0000, 16'h0000);

    // random: alternating fill and drain episodes so the list hits full and empty
    counted      = 0;
    episode_left = 0;
    filling      = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      if (episode_left == 0) begin
        filling      = ~filling;
        episode_left = $urandom_range(10, 40);
      end
      episode_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // noise: spare codes and null pushes, not counted
        case ($urandom_range(0, 3))
          0: queue_cmd(OP_SPARE_6, HANDLE_W'($urandom), KEY_W'($urandom));
          1: queue_cmd(OP_SPARE_7, HANDLE_W'($urandom), KEY_W'($urandom));
          2: queue_cmd(OP_PUSH_FRONT, '0, pick_ident());
          default: queue_cmd(OP_PUSH_BACK, '0, pick_ident());
        endcase
      end else begin
        roll = $urandom_range(0, 99);
        if (filling) begin
          if (roll < 30)      queue_cmd(OP_PUSH_FRONT, pick_handle(), pick_ident());
          else if (roll < 60) queue_cmd(OP_PUSH_BACK, pick_handle(), pick_ident());
          else if (roll < 65) queue_cmd(OP_POP_FRONT, HANDLE_W'($urandom), KEY_W'($urandom));
          else if (roll < 70) queue_cmd(OP_POP_BACK, HANDLE_W'($urandom), KEY_W'($urandom));
          else if (roll < 85) queue_cmd(OP_REMOVE, pick_handle(), KEY_W'($urandom));
          else                queue_cmd(OP_FIND, HANDLE_W'($urandom), pick_ident());
        end else begin
          if (roll < 10)      queue_cmd(OP_PUSH_FRONT, pick_handle(), pick_ident());
          else if (roll < 20) queue_cmd(OP_PUSH_BACK, pick_handle(), pick_ident());
          else if (roll < 40) queue_cmd(OP_POP_FRONT, HANDLE_W'($urandom), KEY_W'($urandom));
          else if (roll < 60) queue_cmd(OP_POP_BACK, HANDLE_W'($urandom), KEY_W'($urandom));
          else if (roll < 85) begin
            // remove: a few null handles among the pool hits
            if ($urandom_range(0, 19) == 0) queue_cmd(OP_REMOVE, '0, KEY_W'($urandom));
            else queue_cmd(OP_REMOVE, pick_handle(), KEY_W'($urandom));
          end else begin
            queue_cmd(OP_FIND, HANDLE_W'($urandom), pick_ident());
          end
        end
        counted++;
      end
    end

    // synchronous reset, once
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // wait for the backlog to go out and every owed result to come back
    while (!timed_out &&
           (cmd_backlog.size() != 0 || in_valid || expected_results.size() != 0)) begin
      @(posedge clk);
    end
    // go on clocking to catch stray results
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (timed_out || expected_results.size() != 0) begin
      $display("TEST FAILED");
    end else if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
